### rtl/core/uia_pkg.sv
package uia_pkg;

  // Widths of the transaction fields, fixed by the interface.
  localparam int unsigned FieldWidth   = 32;
  localparam int unsigned ModeWidth    = 3;

  // Default operating width of the arithmetic.
  localparam int unsigned DefaultWidth = 32;

  // Operation codes carried by the mode field.
  typedef enum logic [ModeWidth-1:0] {
    OpAdd = 3'd0,
    OpSub = 3'd1,
    OpMul = 3'd2,
    OpQuo = 3'd3,
    OpRem = 3'd4,
    OpEq  = 3'd5
  } op_e;

endpackage

### rtl/core/unsigned_integer_alu.sv
// Unsigned integer ALU: add (carry dropped), subtract clamped at zero,
// multiply (low WIDTH bits), floor quotient, remainder and equality on
// WIDTH-bit operands cut from 32-bit ports. One transaction is worked on at
// a time through a single shared WIDTH+1 bit adder/subtractor: add, subtract
// and equality use it directly, while multiply, quotient and remainder run
// the one-bit-per-cycle shift-add and restoring shift-subtract loops through
// it, one step per operand bit. A zero divisor skips the loop. A new
// transaction is taken as soon as the sequencer is idle, even while the
// last result still waits on the output register.
module unsigned_integer_alu #(
  parameter int unsigned WIDTH = uia_pkg::DefaultWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [uia_pkg::ModeWidth-1:0]       mode_i,
  input  logic [uia_pkg::FieldWidth-1:0]      operand_a_i,
  input  logic [uia_pkg::FieldWidth-1:0]      operand_b_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [uia_pkg::FieldWidth-1:0]      result_o,
  output logic                                divide_by_zero_o
);

  import uia_pkg::*;

  localparam int unsigned W    = WIDTH;
  localparam int unsigned MinW = (W < FieldWidth) ? W : FieldWidth;
  localparam int unsigned CntW = $clog2(W + 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    a_q, a_d;
  logic [W-1:0]    b_q, b_d;
  logic [W-1:0]    acc_q, acc_d;
  op_e             op_q;
  logic            dz_q;

  logic                  out_valid_q, out_valid_d;
  logic [FieldWidth-1:0] out_result_q;
  logic                  out_dz_q;

  logic [W-1:0] opa, opb;
  logic         accept, out_free, load_out;
  logic         long_op, in_dz;

  logic [W:0]   unit_x, unit_y, unit_sum;
  logic         unit_sub, unit_carry;

  logic [W-1:0]          final_r;
  logic [FieldWidth-1:0] final_r32;

  // Cut the operands to the working width, or zero extend them.
  always_comb begin
    opa = '0;
    opb = '0;
    opa[MinW-1:0] = operand_a_i[MinW-1:0];
    opb[MinW-1:0] = operand_b_i[MinW-1:0];
  end

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == StDone) && out_free;

  // Quotient and remainder by zero never enter the loop.
  assign in_dz   = ((mode_i == OpQuo) || (mode_i == OpRem)) && (opb == '0);
  assign long_op = ((mode_i == OpMul) || (mode_i == OpQuo) || (mode_i == OpRem)) && !in_dz;

  // The shared adder/subtractor.
  uia_addsub #(
    .Width(W + 1)
  ) u_addsub (
    .x_i    (unit_x),
    .y_i    (unit_y),
    .sub_i  (unit_sub),
    .sum_o  (unit_sum),
    .carry_o(unit_carry)
  );

  // One step of the selected operation per cycle in the run state.
  always_comb begin
    a_d      = a_q;
    b_d      = b_q;
    acc_d    = acc_q;
    unit_x   = {1'b0, a_q};
    unit_y   = {1'b0, b_q};
    unit_sub = 1'b0;
    case (op_q)
      OpAdd: begin
        acc_d = unit_sum[W-1:0];
      end
      OpSub: begin
        unit_sub = 1'b1;
        acc_d    = unit_carry ? unit_sum[W-1:0] : '0;
      end
      OpEq: begin
        unit_sub = 1'b1;
        acc_d    = (unit_sum == '0) ? W'(1) : '0;
      end
      OpMul: begin
        unit_x = {1'b0, acc_q};
        unit_y = {1'b0, a_q};
        if (b_q[0]) begin
          acc_d = unit_sum[W-1:0];
        end
        a_d = {a_q[W-2:0], 1'b0};
        b_d = {1'b0, b_q[W-1:1]};
      end
      OpQuo, OpRem: begin
        // Restoring division: shift the next dividend bit into the partial
        // remainder and subtract the divisor where it fits.
        unit_x   = {acc_q, a_q[W-1]};
        unit_y   = {1'b0, b_q};
        unit_sub = 1'b1;
        if (!dz_q) begin
          if (unit_carry) begin
            acc_d = unit_sum[W-1:0];
            a_d   = {a_q[W-2:0], 1'b1};
          end else begin
            acc_d = unit_x[W-1:0];
            a_d   = {a_q[W-2:0], 1'b0};
          end
        end
      end
      default: begin
        acc_d = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRun;
          cnt_d   = long_op ? CntW'(W) : CntW'(1);
        end
      end
      StRun: begin
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Pick the finished result out of the working registers.
  always_comb begin
    case (op_q)
      OpAdd, OpSub, OpEq, OpMul: final_r = acc_q;
      OpQuo:                     final_r = dz_q ? '1 : a_q;
      OpRem:                     final_r = dz_q ? a_q : acc_q;
      default:                   final_r = '0;
    endcase
    final_r32 = '0;
    final_r32[MinW-1:0] = final_r[MinW-1:0];
  end

  // The output register holds a transaction until the far side takes it.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(mode_i);
      dz_q  <= in_dz;
      a_q   <= opa;
      b_q   <= opb;
      acc_q <= '0;
    end else if (state_q == StRun) begin
      a_q   <= a_d;
      b_q   <= b_d;
      acc_q <= acc_d;
    end
    if (load_out) begin
      out_result_q <= final_r32;
      out_dz_q     <= dz_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_o         = out_result_q;
  assign divide_by_zero_o = out_dz_q;

endmodule

### rtl/core/uia_addsub.sv
module uia_addsub #(
  parameter int unsigned Width = 33
) (
  input  logic [Width-1:0] x_i,
  input  logic [Width-1:0] y_i,
  input  logic             sub_i,
  output logic [Width-1:0] sum_o,
  output logic             carry_o
);

  logic [Width-1:0] y_eff;
  logic [Width:0]   total;

  // Subtraction is done as addition of the inverted operand plus one; the
  // carry out is then high when x is not below y.
  assign y_eff = sub_i ? ~y_i : y_i;
  assign total = {1'b0, x_i} + {1'b0, y_eff} + {{Width{1'b0}}, sub_i};

  assign sum_o   = total[Width-1:0];
  assign carry_o = total[Width];

endmodule

### rtl/core/uia_checker.sv
module uia_checker #(
  parameter int unsigned WIDTH = uia_pkg::DefaultWidth
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [uia_pkg::ModeWidth-1:0]  mode_i,
  input logic [uia_pkg::FieldWidth-1:0] operand_a_i,
  input logic [uia_pkg::FieldWidth-1:0] operand_b_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [uia_pkg::FieldWidth-1:0] result_o,
  input logic                           divide_by_zero_o
);

  import uia_pkg::*;

  localparam int unsigned MinW = (WIDTH < FieldWidth) ? WIDTH : FieldWidth;
  localparam logic [FieldWidth-1:0] CutMask = {FieldWidth{1'b1}} >> (FieldWidth - MinW);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o)
      && $stable(divide_by_zero_o))
    else $error("stalled result changed");

  // The block is busy in the cycle after it takes a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after a transaction was taken");

  // The block only becomes busy by taking a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stalled without a transaction");

  // An equality test taken on an empty output passes the run and done states, then shows its answer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (mode_i == OpEq) && !out_valid_o |-> ##3 out_valid_o
      && !divide_by_zero_o
      && (result_o == (((($past(operand_a_i, 3) ^ $past(operand_b_i, 3)) & CutMask) == '0)
                        ? FieldWidth'(1) : '0)))
    // The operands are sampled at acceptance and compared after the delay.
    else $error("equality result wrong or late");

endmodule

bind unsigned_integer_alu uia_checker #(.WIDTH(WIDTH)) u_uia_checker (.*);
